// ===== design/wildcard_subscription_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// wildcard subscription matcher assertion macros
// Shared concurrent assertion wrappers for the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_SUBSCRIPTION_MATCHER_ASSERT_SVH
`define WILDCARD_SUBSCRIPTION_MATCHER_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define WSM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the module's own i_clk and i_rst_n
`define WSM_ASSERT(label, prop, msg) \
    `WSM_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== design/wsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wsm_pkg
// Types and constants shared by the matcher controller, datapath and top.
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int KEY_W    = 8;
    localparam int SUB_W    = 8;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 4 * KEY_W + SUB_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_REGISTERED = 3'd0,
        ST_MATCH      = 3'd1,
        ST_NO_MATCH   = 3'd2,
        ST_FULL       = 3'd3,
        ST_NULL_SUB   = 3'd4
    } t_status;

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_MATCH    = 1'b1
    } t_opcode;

    // first member sits in the top bits, so type_key lands in bits 7:0
    typedef struct packed {
        logic [SUB_W-1:0] subscriber_id;
        logic [KEY_W-1:0] room_key;
        logic [KEY_W-1:0] floor_key;
        logic [KEY_W-1:0] building_key;
        logic [KEY_W-1:0] type_key;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REG,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic do_reg;
        logic scan_start;
        logic scan_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic scan_done;
    } t_stat;

endpackage

// ===== design/wildcard_subscription_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_subscription_matcher
// Subscription table with wildcard key matching: register items append
// entries, match items stream out every fitting subscriber in insertion order.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                      tuser        tlast
//  s_axis    in   type, building, floor, room, subscriber    opcode       -
//  m_axis    out  matched_subscriber                         status       last
//
//  register item: result loaded into the output register from S_REG once it is free
//  match item: table scan, then the final result loaded from S_FINISH; one table
//    entry read per cycle from the single read port of the entry memory, unless
//    the scan is held while a result waits on m_axis
//  the next item can be accepted in the cycle after the final result is loaded
//  synchronous active-low reset clears the fill count; the table needs no clear
//  m_axis_tready low holds the scan only when a second fit is ready to go out
// ----------------------------------------------------------------------------
module wildcard_subscription_matcher #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] type_key, [15:8] building_key, [23:16] floor_key,
    // [31:24] room_key, [39:32] subscriber_id
    input  logic [39:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] matched_subscriber
    output logic [7:0]  m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import wsm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wsm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_sub    (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

// ===== design/wsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsm_ctrl
// Sequencer for the matcher: takes an item, then runs a register step or a
// table scan followed by the closing result.
// ----------------------------------------------------------------------------
module wsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    input  wsm_pkg::t_stat i_stat,
    output wsm_pkg::t_cmd  o_cmd
);
    import wsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (t_opcode'(i_in_op) == OP_MATCH) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        n_state = S_REG;
                    end
                end
            end
            S_REG: begin
                o_cmd.do_reg = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/wsm_dp.sv =====
// ----------------------------------------------------------------------------
// wsm_dp
// Entry table memory, fill count, scan pipeline (read, compare, hold one
// pending fit) and the result output register.
// ----------------------------------------------------------------------------
`include "wildcard_subscription_matcher_assert.svh"

module wsm_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wsm_pkg::ENTRY_W-1:0]   i_in_data,
    input  wsm_pkg::t_cmd                 i_cmd,
    output wsm_pkg::t_stat                o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [wsm_pkg::STATUS_W-1:0]  o_out_status,
    output logic [wsm_pkg::SUB_W-1:0]     o_out_sub,
    output logic                          o_out_last
);
    import wsm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_entry mem [TABLE_DEPTH];

    t_entry             r_ev;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_addr;
    logic               r_cmp_vld;
    t_entry             r_rd;
    logic               r_pend_vld;
    logic [SUB_W-1:0]   r_pend_sub;
    logic               r_out_vld;
    t_status            r_out_status;
    logic [SUB_W-1:0]   r_out_sub;
    logic               r_out_last;

    logic               n_out_vld;
    t_status            n_out_status;
    logic [SUB_W-1:0]   n_out_sub;
    logic               n_out_last;

    logic out_free;
    logic issue;
    logic fit;
    logic step;
    logic scan_emit;
    logic is_null;
    logic is_full;
    logic reg_done;
    logic mem_we;
    logic fin_done;

    always_comb begin
        out_free = !r_out_vld || i_out_ready;
        // a stored key of zero is a wildcard
        fit = r_cmp_vld
            && (r_rd.type_key     == '0 || r_rd.type_key     == r_ev.type_key)
            && (r_rd.building_key == '0 || r_rd.building_key == r_ev.building_key)
            && (r_rd.floor_key    == '0 || r_rd.floor_key    == r_ev.floor_key)
            && (r_rd.room_key     == '0 || r_rd.room_key     == r_ev.room_key);
        // the held fit goes out when a newer one shows up; stall if output busy
        step      = !(fit && r_pend_vld && !out_free);
        issue     = i_cmd.scan_en && step && (r_addr < r_count);
        scan_emit = i_cmd.scan_en && fit && r_pend_vld && out_free;
        is_null   = (r_ev.subscriber_id == '0);
        is_full   = (r_count >= CW'(TABLE_DEPTH));
        reg_done  = i_cmd.do_reg && out_free;
        mem_we    = reg_done && !is_null && !is_full;
        fin_done  = i_cmd.finish && out_free;
    end

    always_comb begin
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_status = r_out_status;
        n_out_sub    = r_out_sub;
        n_out_last   = r_out_last;
        if (reg_done) begin
            n_out_vld    = 1'b1;
            n_out_sub    = '0;
            n_out_last   = 1'b1;
            if (is_null) begin
                n_out_status = ST_NULL_SUB;
            end else if (is_full) begin
                n_out_status = ST_FULL;
            end else begin
                n_out_status = ST_REGISTERED;
            end
        end else if (scan_emit) begin
            n_out_vld    = 1'b1;
            n_out_status = ST_MATCH;
            n_out_sub    = r_pend_sub;
            n_out_last   = 1'b0;
        end else if (fin_done) begin
            n_out_vld  = 1'b1;
            n_out_last = 1'b1;
            if (r_pend_vld) begin
                n_out_status = ST_MATCH;
                n_out_sub    = r_pend_sub;
            end else begin
                n_out_status = ST_NO_MATCH;
                n_out_sub    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_addr     <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (mem_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_addr     <= '0;
                r_cmp_vld  <= 1'b0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.scan_en && step) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (fit) begin
                    r_pend_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ev <= t_entry'(i_in_data);
        end
        if (i_cmd.scan_en && step && fit) begin
            r_pend_sub <= r_rd.subscriber_id;
        end
        r_out_status <= n_out_status;
        r_out_sub    <= n_out_sub;
        r_out_last   <= n_out_last;
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= r_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd <= mem[r_addr[AW-1:0]];
        end
    end

    assign o_stat.out_free  = out_free;
    assign o_stat.scan_done = (r_addr == r_count) && !r_cmp_vld;

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_sub    = r_out_sub;
    assign o_out_last   = r_out_last;

    `WSM_ASSERT(a_count_bound, r_count <= CW'(TABLE_DEPTH), "entry count beyond table depth")
    `WSM_ASSERT(a_read_in_range, issue |-> (r_addr < r_count), "scan read past stored entries")
    `WSM_ASSERT(a_emit_not_last, scan_emit |=> (r_out_vld && r_out_status == ST_MATCH && !r_out_last), "mid-scan result malformed")
    `WSM_ASSERT(a_write_grows, mem_we |=> (r_count == $past(r_count) + CW'(1)), "table write without count growth")

endmodule

// ===== bench/wsm_checker.sv =====
// ----------------------------------------------------------------------------
// wsm_checker
// Watches both stream channels of the subscription matcher, keeps its own
// copy of the subscriber table, works out the answers of every accepted item
// and compares each returned transfer with the oldest answer still owed.
// ----------------------------------------------------------------------------
module wsm_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [7:0] type_key, [15:8] building_key, [23:16] floor_key,
    // [31:24] room_key, [39:32] subscriber_id
    input  logic [39:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] matched_subscriber
    input  logic [7:0]  m_axis_tdata,
    // [2:0] status
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsm_pkg::*;

    typedef struct {
        t_status          status;
        logic [SUB_W-1:0] subscriber;
        logic             last;
    } t_answer;

    t_entry  sub_table [TABLE_DEPTH];
    int      sub_count  = 0;
    t_answer answer_q [$];
    int      mismatches = 0;

    task automatic post(input t_status st, input logic [SUB_W-1:0] sub, input logic lst);
        t_answer a;
        a.status     = st;
        a.subscriber = sub;
        a.last       = lst;
        answer_q.insert(answer_q.size(), a);
    endtask

    // stored key 0 is the wildcard, event key 0 is an ordinary value
    function automatic bit key_ok(input logic [KEY_W-1:0] stored, input logic [KEY_W-1:0] ev);
        return (stored == '0) || (stored == ev);
    endfunction

    task automatic apply_item(input t_opcode op, input t_entry item);
        int fits;
        fits = 0;
        if (op == OP_REGISTER) begin
            // null check comes ahead of the full check
            if (item.subscriber_id == '0) begin
                post(ST_NULL_SUB, '0, 1'b1);
            end else if (sub_count >= TABLE_DEPTH) begin
                post(ST_FULL, '0, 1'b1);
            end else begin
                sub_table[sub_count] = item;
                sub_count++;
                post(ST_REGISTERED, '0, 1'b1);
            end
        end else begin
            for (int i = 0; i < sub_count; i++) begin
                if (key_ok(sub_table[i].type_key, item.type_key) &&
                    key_ok(sub_table[i].building_key, item.building_key) &&
                    key_ok(sub_table[i].floor_key, item.floor_key) &&
                    key_ok(sub_table[i].room_key, item.room_key)) begin
                    post(ST_MATCH, sub_table[i].subscriber_id, 1'b0);
                    fits++;
                end
            end
            if (fits == 0) begin
                post(ST_NO_MATCH, '0, 1'b1);
            end else begin
                answer_q[answer_q.size() - 1].last = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            sub_count = 0;
            answer_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t wsm_checker: unexpected transfer status %0d sub %0d last %0b",
                                 $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want = answer_q.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata !== want.subscriber ||
                        m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t wsm_checker: want status %0d sub %0d last %0b,",
                                     $realtime, want.status, want.subscriber, want.last,
                                     " got status %0d sub %0d last %0b",
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(t_opcode'(s_axis_tuser), t_entry'(s_axis_tdata));
            end
        end
        o_pending    <= answer_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives register and match items into the subscription matcher with random
// gaps and output stalls, lets the checker score every result transfer, and
// prints the verdict once all owed results have come back.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsm_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 220;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending_count;
    int quiet_cycles = 0;
    bit hold_req     = 1'b0;

    always #5 i_clk = ~i_clk;

    wildcard_subscription_matcher #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    wsm_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    function automatic t_entry pack_item(input logic [7:0] t, input logic [7:0] b,
                                         input logic [7:0] f, input logic [7:0] r,
                                         input logic [7:0] s);
        t_entry e;
        e.type_key      = t;
        e.building_key  = b;
        e.floor_key     = f;
        e.room_key      = r;
        e.subscriber_id = s;
        return e;
    endfunction

    // small key pool so that events actually hit stored entries
    function automatic logic [7:0] draw_key(input bit wild_heavy);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < (wild_heavy ? 8 : 3)) return 8'd0;
        if (pick < 14) return 8'($urandom_range(1, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // valid stays high from one transfer to the next when gap is zero
    task automatic push_item(input t_opcode op, input t_entry item, input int gap);
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // watchdog on cycles without any transfer
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // result side: random stalls, quiet stretches, one long hold-off
    initial begin
        int  gap;
        int  taken;
        bit  hold_done;
        taken     = 0;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            gap = (taken % 60 < 20) ? 0 : $urandom_range(0, 17);
            for (int k = 0; k < gap; k++) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    initial begin
        t_opcode op;
        t_entry  item;
        int      gap;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, null subscriber, key extremes, event key zero
        push_item(OP_MATCH,    pack_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd0), $urandom_range(0, 17));
        push_item(OP_REGISTER, pack_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0),
                  $urandom_range(0, 17));
        push_item(OP_REGISTER, pack_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd1), $urandom_range(0, 17));
        push_item(OP_REGISTER, pack_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  $urandom_range(0, 17));
        push_item(OP_REGISTER, pack_item(8'd1, 8'd2, 8'd3, 8'd4, 8'h80), $urandom_range(0, 17));
        push_item(OP_REGISTER, pack_item(8'd1, 8'd0, 8'd3, 8'd0, 8'h7F), $urandom_range(0, 17));
        push_item(OP_MATCH,    pack_item(8'd1, 8'd2, 8'd3, 8'd4, 8'd0), $urandom_range(0, 17));
        push_item(OP_MATCH,    pack_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  $urandom_range(0, 17));
        push_item(OP_MATCH,    pack_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
        push_item(OP_MATCH,    pack_item(8'd1, 8'd9, 8'd3, 8'd9, 8'h55), 0);
        push_item(OP_REGISTER, pack_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
        push_item(OP_MATCH,    pack_item(8'd1, 8'd2, 8'd3, 8'hFF, 8'hAA), $urandom_range(0, 17));
        push_item(OP_MATCH,    pack_item(8'd7, 8'd7, 8'd7, 8'd7, 8'd0), $urandom_range(0, 17));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60) hold_req = 1'b1;
            if (n == 140) wait_drained();
            if ($urandom_range(0, 99) < 40) begin
                op   = OP_REGISTER;
                item = pack_item(draw_key(1'b1), draw_key(1'b1), draw_key(1'b1),
                                 draw_key(1'b1), 8'd0);
                item.subscriber_id = ($urandom_range(0, 15) == 0) ? 8'd0
                                                                  : 8'($urandom_range(1, 255));
            end else begin
                op   = OP_MATCH;
                item = pack_item(draw_key(1'b0), draw_key(1'b0), draw_key(1'b0),
                                 draw_key(1'b0), 8'($urandom_range(0, 255)));
            end
            gap = (n % 50 < 12) ? 0 : $urandom_range(0, 17);
            push_item(op, item, gap);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== wildcard_subscription_matcher.f =====
+incdir+design
design/wsm_pkg.sv
design/wsm_ctrl.sv
design/wsm_dp.sv
design/wildcard_subscription_matcher.sv
bench/wsm_checker.sv
bench/tb_top.sv
